// ----- rtl/core/sgbi_pkg.sv -----
// Shared constants and codes of the grid bucketing engine.
`timescale 1ns / 1ps
package sgbi_pkg;
	localparam int COORD_W   = 24;
	localparam int Q_W       = 23;
	localparam int CNT_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int STATUS_W  = 2;
	localparam int CELL_OUT_W = 12;
	localparam int SLOT_OUT_W = 12;
	localparam int LINK_OUT_W = 13;
	localparam int IDX_W     = Q_W + 2 * CNT_W + 1;
	localparam int DIV_CNT_W = $clog2(Q_W);

	localparam int DEF_MAX_CELLS = 4096;
	localparam int DEF_MAX_NODES = 4096;
	localparam int DEF_ITEM_BITS = 32;

	localparam logic [LINK_OUT_W-1:0] LINK_NONE = 13'd4096;

	localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd5;
endpackage

// ----- rtl/core/sgbi_ifs.sv -----
// Handshake channel interfaces of the grid bucketing engine.
`timescale 1ns / 1ps
interface sgbi_req_if #(parameter int ITEM_BITS = sgbi_pkg::DEF_ITEM_BITS);
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic [ITEM_BITS-1:0]               item_handle;
	logic signed [sgbi_pkg::COORD_W-1:0] pos_x;
	logic signed [sgbi_pkg::COORD_W-1:0] pos_y;
	logic signed [sgbi_pkg::COORD_W-1:0] pos_z;
	modport source(output valid, operation, item_handle, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, operation, item_handle, pos_x, pos_y, pos_z, output ready);
endinterface

interface sgbi_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sgbi_pkg::STATUS_W-1:0]       status;
	logic [sgbi_pkg::CELL_OUT_W-1:0]     cell_number;
	logic [sgbi_pkg::SLOT_OUT_W-1:0]     node_slot;
	logic [sgbi_pkg::LINK_OUT_W-1:0]     next_link;
	logic                                was_empty;
	modport source(output valid, status, cell_number, node_slot, next_link, was_empty,
		input ready);
	modport sink(input valid, status, cell_number, node_slot, next_link, was_empty,
		output ready);
endinterface

interface sgbi_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sgbi_pkg::CFG_IDX_W-1:0]     index;
	logic [sgbi_pkg::Q_W-1:0]           data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/spatial_grid_bucket_insert_unit.sv -----
// Top level of the uniform grid bucketing engine.
`timescale 1ns / 1ps
// Uniform grid bucketing engine.
// req: one item per handshake. operation insert carries a handle and a signed
//   Q15.8 position; operation clear empties every cell and resets the pool.
// rsp: one result item per request: status, cell, slot, old head, empty flag.
// cfg: register writes (limits, cell edge, cell counts); always ready, and
//   meant to be written only while the engine is idle.
// An insert passes these steps from acceptance to rsp.valid: the three
//   restoring dividers (one quotient bit per cycle, three lanes side by side),
//   two multiply stages, one add, the bound check with the head table read,
//   the write back with the pool update, and the load of the output register.
//   A dropped item skips the write back.
// Items are handled one at a time: req.ready is high only in the idle state.
// A clear sweeps the head table, one cell per cycle, and then passes its
//   result to the output register.
// After reset the same sweep runs with req.ready low; cfg writes are taken
//   during it.
// The result sits in an output register, so the next item is taken while it
//   waits; if rsp stalls, the engine holds its finished result in its last
//   step until the register frees.
module spatial_grid_bucket_insert_unit #(
	parameter int MAX_CELLS = sgbi_pkg::DEF_MAX_CELLS,
	parameter int MAX_NODES = sgbi_pkg::DEF_MAX_NODES,
	parameter int ITEM_BITS = sgbi_pkg::DEF_ITEM_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	sgbi_req_if.sink req,
	sgbi_rsp_if.source rsp,
	sgbi_cfg_if.sink cfg
);
	localparam int CELL_W = $clog2(MAX_CELLS);
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int POOL_W = $clog2(MAX_NODES + 1);
	localparam int QW = sgbi_pkg::Q_W;
	localparam int CW = sgbi_pkg::CNT_W;
	localparam int IW = sgbi_pkg::IDX_W;
	localparam int DW = sgbi_pkg::DIV_CNT_W;

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_MUL1  = 4'd3;
	localparam logic [3:0] S_MUL2  = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_CHECK = 4'd6;
	localparam logic [3:0] S_READ  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	// config registers
	logic [QW-1:0] lim_q [3];
	logic [QW-1:0] edge_cfg_q;
	logic [CW-1:0] cells_x_q, cells_y_q;

	// control
	logic [3:0]        state_q;
	logic [CELL_W-1:0] sweep_q;
	logic              clear_pend_q;
	logic [DW-1:0]     div_cnt_q;
	logic [POOL_W-1:0] pool_top_q;

	// datapath
	logic [ITEM_BITS-1:0] item_q;
	logic [QW-1:0]        divisor_q;
	logic [QW-1:0]        rem_q [3];
	logic [QW-1:0]        quo_q [3];
	logic [QW+CW-1:0]     p1_q;
	logic [2*CW-1:0]      pxy_q;
	logic [QW+2*CW-1:0]   p2_q;
	logic [QW+CW:0]       sum_a_q;
	logic [IW-1:0]        idx_q;

	// result staging and output register
	logic [sgbi_pkg::STATUS_W-1:0]   res_status_q;
	logic [sgbi_pkg::CELL_OUT_W-1:0] res_cell_q;
	logic [sgbi_pkg::SLOT_OUT_W-1:0] res_slot_q;
	logic [sgbi_pkg::LINK_OUT_W-1:0] res_link_q;
	logic                            res_empty_q;
	logic                            out_valid_q;

	// memories: head entry is {valid, slot}
	logic [NODE_W:0]      head_mem [MAX_CELLS];
	logic [NODE_W-1:0]    tail_mem [MAX_CELLS];
	logic [ITEM_BITS-1:0] item_mem [MAX_NODES];
	logic [sgbi_pkg::LINK_OUT_W-1:0] link_mem [MAX_NODES];
	logic [NODE_W:0]      head_rd_q;

	logic req_fire, out_load, head_we, ins_we, head_empty;
	logic [CELL_W-1:0] head_waddr;
	logic [NODE_W:0]   head_wdata;
	logic [QW-1:0]     clamp [3];
	logic signed [sgbi_pkg::COORD_W-1:0] pos [3];
	logic [sgbi_pkg::LINK_OUT_W-1:0] new_link;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign pos[0] = req.pos_x;
	assign pos[1] = req.pos_y;
	assign pos[2] = req.pos_z;

	// clamp to [0, limit]
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (pos[l][sgbi_pkg::COORD_W-1])
				clamp[l] = '0;
			else if (pos[l][QW-1:0] > lim_q[l])
				clamp[l] = lim_q[l];
			else
				clamp[l] = pos[l][QW-1:0];
		end
	end

	assign head_empty = !head_rd_q[NODE_W];
	assign new_link   = head_empty ? sgbi_pkg::LINK_NONE
		: sgbi_pkg::LINK_OUT_W'(head_rd_q[NODE_W-1:0]);
	assign ins_we     = (state_q == S_READ);
	assign head_we    = (state_q == S_SWEEP) || ins_we;
	assign head_waddr = (state_q == S_SWEEP) ? sweep_q : idx_q[CELL_W-1:0];
	assign head_wdata = (state_q == S_SWEEP) ? '0 : {1'b1, pool_top_q[NODE_W-1:0]};

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_waddr] <= head_wdata;
		if (state_q == S_CHECK)
			head_rd_q <= head_mem[idx_q[CELL_W-1:0]];
		if (ins_we) begin
			item_mem[pool_top_q[NODE_W-1:0]] <= item_q;
			link_mem[pool_top_q[NODE_W-1:0]] <= new_link;
			if (head_empty)
				tail_mem[idx_q[CELL_W-1:0]] <= pool_top_q[NODE_W-1:0];
		end
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[0]   <= '0;
			lim_q[1]   <= '0;
			lim_q[2]   <= '0;
			edge_cfg_q <= QW'(256);
			cells_x_q  <= CW'(1);
			cells_y_q  <= CW'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sgbi_pkg::REG_X_LIMIT: lim_q[0]   <= cfg.data;
				sgbi_pkg::REG_Y_LIMIT: lim_q[1]   <= cfg.data;
				sgbi_pkg::REG_Z_LIMIT: lim_q[2]   <= cfg.data;
				sgbi_pkg::REG_EDGE:    edge_cfg_q <= cfg.data;
				sgbi_pkg::REG_CELLS_X: cells_x_q  <= cfg.data[CW-1:0];
				sgbi_pkg::REG_CELLS_Y: cells_y_q  <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			clear_pend_q <= 1'b0;
			div_cnt_q    <= '0;
			pool_top_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					if (sweep_q == CELL_W'(MAX_CELLS - 1)) begin
						sweep_q <= '0;
						state_q <= clear_pend_q ? S_DONE : S_IDLE;
						clear_pend_q <= 1'b0;
					end else begin
						sweep_q <= sweep_q + CELL_W'(1);
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						if (req.operation == sgbi_pkg::OP_CLEAR) begin
							pool_top_q   <= '0;
							clear_pend_q <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DW'(1);
					if (div_cnt_q == DW'(QW - 1))
						state_q <= S_MUL1;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_SUM;
				S_SUM:   state_q <= S_CHECK;
				S_CHECK: begin
					if (idx_q >= IW'(MAX_CELLS) || pool_top_q >= POOL_W'(MAX_NODES))
						state_q <= S_DONE;
					else
						state_q <= S_READ;
				end
				S_READ: begin
					pool_top_q <= pool_top_q + POOL_W'(1);
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: dividers, index arithmetic, result staging and the output register
	always_ff @(posedge clk) begin
		logic [QW:0] trial;
		if (req_fire) begin
			item_q    <= req.item_handle;
			divisor_q <= (edge_cfg_q == '0) ? QW'(1) : edge_cfg_q;
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= '0;
				quo_q[l] <= clamp[l];
			end
		end
		if (state_q == S_DIV) begin
			// restoring division, one quotient bit per lane per cycle
			for (int l = 0; l < 3; l++) begin
				trial = {rem_q[l], quo_q[l][QW-1]};
				if (trial >= {1'b0, divisor_q}) begin
					rem_q[l] <= QW'(trial - {1'b0, divisor_q});
					quo_q[l] <= {quo_q[l][QW-2:0], 1'b1};
				end else begin
					rem_q[l] <= trial[QW-1:0];
					quo_q[l] <= {quo_q[l][QW-2:0], 1'b0};
				end
			end
		end
		if (state_q == S_MUL1) begin
			p1_q  <= (QW+CW)'(quo_q[1]) * (QW+CW)'(cells_x_q);
			pxy_q <= (2*CW)'(cells_x_q) * (2*CW)'(cells_y_q);
		end
		if (state_q == S_MUL2) begin
			p2_q    <= (QW+2*CW)'(quo_q[2]) * (QW+2*CW)'(pxy_q);
			sum_a_q <= (QW+CW+1)'(quo_q[0]) + (QW+CW+1)'(p1_q);
		end
		if (state_q == S_SUM)
			idx_q <= IW'(sum_a_q) + IW'(p2_q);
		if (state_q == S_CHECK) begin
			res_slot_q  <= '0;
			res_link_q  <= '0;
			res_empty_q <= 1'b0;
			if (idx_q >= IW'(MAX_CELLS)) begin
				res_status_q <= sgbi_pkg::ST_RANGE;
				res_cell_q   <= '0;
			end else begin
				res_status_q <= sgbi_pkg::ST_FULL;
				res_cell_q   <= sgbi_pkg::CELL_OUT_W'(idx_q);
			end
		end
		if (ins_we) begin
			res_status_q <= sgbi_pkg::ST_STORED;
			res_slot_q   <= sgbi_pkg::SLOT_OUT_W'(pool_top_q);
			res_link_q   <= new_link;
			res_empty_q  <= head_empty;
		end
		if (state_q == S_SWEEP && clear_pend_q) begin
			res_status_q <= sgbi_pkg::ST_CLEARED;
			res_cell_q   <= '0;
			res_slot_q   <= '0;
			res_link_q   <= '0;
			res_empty_q  <= 1'b0;
		end
		if (out_load) begin
			rsp.status      <= res_status_q;
			rsp.cell_number <= res_cell_q;
			rsp.node_slot   <= res_slot_q;
			rsp.next_link   <= res_link_q;
			rsp.was_empty   <= res_empty_q;
		end
	end

	assign rsp.valid = out_valid_q;
endmodule
